// ----- rtl/lmsanc_pkg.sv -----
// ----------------------------------------------------------------------------
// LMS noise canceller package
// Field widths, request and result types, register indexes and the fixed
// arithmetic widths shared by the datapath and the serial multiplier.
// ----------------------------------------------------------------------------
package lmsanc_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int WEIGHT_W   = 32;
	localparam int STEP_W     = 20;
	localparam int TAPS_CFG_W = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 20;

	// mu * error is exact in MUE_W bits; times a sample it is exact in PROD_W
	localparam int MUE_W  = STEP_W + 1 + SAMPLE_W;
	localparam int PROD_W = MUE_W + SAMPLE_W;
	localparam int WSUM_W = WEIGHT_W + 2;

	localparam int MUL_CNT_W = $clog2(SAMPLE_W);

	localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_TAPS = 2'd1;

	localparam logic [STEP_W-1:0]     STEP_RESET = 20'd15099;
	localparam logic [TAPS_CFG_W-1:0] TAPS_RESET = 4'd5;

	localparam logic signed [SAMPLE_W-1:0] SMP_MAX = 16'sh7FFF;
	localparam logic signed [SAMPLE_W-1:0] SMP_MIN = 16'sh8000;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] ref_sample;
		logic signed [SAMPLE_W-1:0] desired_sample;
		logic                       first_sample;
	} sample_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] error_sample;
		logic signed [SAMPLE_W-1:0] estimate_sample;
	} result_t;

endpackage

// ----- rtl/lmsanc_serial_mul.sv -----
// ----------------------------------------------------------------------------
// LMS noise canceller serial multiplier
// Signed shift-and-add multiplier: the multiplier operand is consumed one
// bit per cycle, LSB first; the sign bit carries negative weight.
// ----------------------------------------------------------------------------
module lmsanc_serial_mul (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     start,
	input  logic signed [lmsanc_pkg::MUE_W-1:0]      a,
	input  logic signed [lmsanc_pkg::SAMPLE_W-1:0]   b,
	output logic                                     done,
	output logic signed [lmsanc_pkg::PROD_W-1:0]     prod
);

	logic                                   busy_q;
	logic                                   done_q;
	logic [lmsanc_pkg::MUL_CNT_W-1:0]       cnt_q;
	logic signed [lmsanc_pkg::PROD_W-1:0]   a_sh_q;
	logic [lmsanc_pkg::SAMPLE_W-1:0]        b_sh_q;
	logic signed [lmsanc_pkg::PROD_W-1:0]   prod_q;
	logic                                   last_bit;

	assign last_bit = (cnt_q == lmsanc_pkg::MUL_CNT_W'(lmsanc_pkg::SAMPLE_W - 1));

	// sequence the bit count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (last_bit) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// add or subtract the shifted multiplicand, advance both shift registers
	always_ff @(posedge clk) begin
		if (start) begin
			a_sh_q <= lmsanc_pkg::PROD_W'(a);
			b_sh_q <= b;
			prod_q <= '0;
		end else if (busy_q) begin
			if (b_sh_q[0]) begin
				if (last_bit) begin
					prod_q <= prod_q - a_sh_q;
				end else begin
					prod_q <= prod_q + a_sh_q;
				end
			end
			a_sh_q <= a_sh_q <<< 1;
			b_sh_q <= b_sh_q >> 1;
		end
	end

	assign done = done_q;
	assign prod = prod_q;

endmodule

// ----- rtl/lms_adaptive_noise_canceller.sv -----
// ----------------------------------------------------------------------------
// One request at a time: both passes visit every tap of the ring, multiplying
// at active taps and only rotating idle ones. A request is taken the cycle after
// the result is loaded, and a stalled result holds the next request off.
// Reset clears history, weights and handshakes and restores step 15099,
// five taps. No clearing pass.
// ----------------------------------------------------------------------------
// LMS adaptive noise canceller
// Delay line and weights circulate as rings read at their head; the
// estimate pass and the weight update pass share the serial multiplier.
// ----------------------------------------------------------------------------
module lms_adaptive_noise_canceller #(
	parameter int TAPS = 8
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   sample_valid,
	output logic                                   sample_ready,
	input  lmsanc_pkg::sample_t                    sample,
	output logic                                   result_valid,
	input  logic                                   result_ready,
	output lmsanc_pkg::result_t                    result,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [lmsanc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [lmsanc_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int KW    = (TAPS > 1) ? $clog2(TAPS) : 1;
	localparam int MW    = ($clog2(TAPS + 1) > lmsanc_pkg::TAPS_CFG_W) ?
	                       $clog2(TAPS + 1) : lmsanc_pkg::TAPS_CFG_W;
	localparam int ACC_W = lmsanc_pkg::WEIGHT_W + lmsanc_pkg::SAMPLE_W + $clog2(TAPS) + 1;
	localparam int SW    = lmsanc_pkg::SAMPLE_W;
	localparam int PW    = lmsanc_pkg::PROD_W;
	localparam int WS    = lmsanc_pkg::WSUM_W;

	localparam logic signed [ACC_W-1:0] EST_MAX = ACC_W'(64'sd32767);
	localparam logic signed [ACC_W-1:0] EST_MIN = ACC_W'(-64'sd32768);
	localparam logic signed [WS-1:0]    W_MAX   = WS'(64'sd2147483647);
	localparam logic signed [WS-1:0]    W_MIN   = WS'(-64'sd2147483648);

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_EST     = 3'd1;
	localparam logic [2:0] ST_EST_MUL = 3'd2;
	localparam logic [2:0] ST_ERR     = 3'd3;
	localparam logic [2:0] ST_MUE     = 3'd4;
	localparam logic [2:0] ST_UPD     = 3'd5;
	localparam logic [2:0] ST_UPD_MUL = 3'd6;
	localparam logic [2:0] ST_DONE    = 3'd7;

	logic [2:0]                               state_q;
	logic [KW-1:0]                            k_q;
	logic [MW-1:0]                            m_q;
	logic [MW-1:0]                            act_ext;
	logic [lmsanc_pkg::STEP_W-1:0]            step_q;
	logic [lmsanc_pkg::TAPS_CFG_W-1:0]        taps_q;
	logic signed [SW-1:0]                     d_q;
	logic signed [ACC_W-1:0]                  acc_q;
	logic signed [SW-1:0]                     est_q;
	logic signed [SW-1:0]                     err_q;
	logic signed [lmsanc_pkg::MUE_W-1:0]      mue_q;
	logic signed [SW-1:0]                     hist_q [TAPS];
	logic signed [lmsanc_pkg::WEIGHT_W-1:0]   w_q [TAPS];
	logic                                     res_valid_q;
	lmsanc_pkg::result_t                      res_q;

	logic                                     accept;
	logic                                     tap_active;
	logic                                     tap_last;
	logic                                     rotate;
	logic                                     write_tail;
	logic                                     res_load;
	logic                                     mul_start;
	logic signed [lmsanc_pkg::MUE_W-1:0]      mul_a;
	logic signed [SW-1:0]                     mul_b;
	logic                                     mul_done;
	logic signed [PW-1:0]                     mul_prod;
	logic signed [ACC_W-1:0]                  acc_rnd;
	logic signed [ACC_W-1:0]                  est_full;
	logic signed [SW-1:0]                     est_sat;
	logic signed [SW:0]                       err_full;
	logic signed [SW-1:0]                     err_sat;
	logic signed [PW-1:0]                     p_rnd;
	logic signed [PW-1:0]                     delta_full;
	logic signed [WS-1:0]                     w_sum;
	logic signed [lmsanc_pkg::WEIGHT_W-1:0]   w_new;

	assign sample_ready = (state_q == ST_IDLE);
	assign accept       = sample_valid && sample_ready;
	assign cfg_ready    = 1'b1;
	assign tap_active   = (MW'(k_q) < m_q);
	assign tap_last     = (k_q == KW'(TAPS - 1));
	assign res_load     = (state_q == ST_DONE) && (!res_valid_q || result_ready);
	assign act_ext      = MW'(taps_q);

	// configuration registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= lmsanc_pkg::STEP_RESET;
			taps_q <= lmsanc_pkg::TAPS_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				lmsanc_pkg::REG_STEP_SIZE:   step_q <= cfg_data[lmsanc_pkg::STEP_W-1:0];
				lmsanc_pkg::REG_ACTIVE_TAPS: taps_q <= cfg_data[lmsanc_pkg::TAPS_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// estimate rounding and saturation, then the saturated error
	always_comb begin
		acc_rnd  = acc_q + $signed({{(ACC_W-24){1'b0}}, 1'b1, 23'b0});
		est_full = acc_rnd >>> 24;
		if (est_full > EST_MAX) begin
			est_sat = lmsanc_pkg::SMP_MAX;
		end else if (est_full < EST_MIN) begin
			est_sat = lmsanc_pkg::SMP_MIN;
		end else begin
			est_sat = est_full[SW-1:0];
		end
		err_full = (SW+1)'(d_q) - (SW+1)'(est_sat);
		if (err_full[SW] != err_full[SW-1]) begin
			err_sat = err_full[SW] ? lmsanc_pkg::SMP_MIN : lmsanc_pkg::SMP_MAX;
		end else begin
			err_sat = err_full[SW-1:0];
		end
	end

	// weight update: round the Q54 product to Q24, add, saturate
	always_comb begin
		p_rnd      = mul_prod + $signed({{(PW-30){1'b0}}, 1'b1, 29'b0});
		delta_full = p_rnd >>> 30;
		w_sum      = WS'(w_q[0]) + WS'(delta_full);
		if (w_sum > W_MAX) begin
			w_new = W_MAX[lmsanc_pkg::WEIGHT_W-1:0];
		end else if (w_sum < W_MIN) begin
			w_new = W_MIN[lmsanc_pkg::WEIGHT_W-1:0];
		end else begin
			w_new = w_sum[lmsanc_pkg::WEIGHT_W-1:0];
		end
	end

	// multiplier operands and ring control per state
	always_comb begin
		mul_start  = 1'b0;
		mul_a      = lmsanc_pkg::MUE_W'(w_q[0]);
		mul_b      = hist_q[0];
		rotate     = 1'b0;
		write_tail = 1'b0;
		unique case (state_q)
			ST_EST: begin
				mul_start = tap_active;
				rotate    = !tap_active;
			end
			ST_EST_MUL: begin
				rotate = mul_done;
			end
			ST_ERR: begin
				mul_start = 1'b1;
				mul_a     = $signed({{(lmsanc_pkg::MUE_W-lmsanc_pkg::STEP_W){1'b0}}, step_q});
				mul_b     = err_sat;
			end
			ST_UPD: begin
				mul_start = tap_active;
				mul_a     = mue_q;
				rotate    = !tap_active;
			end
			ST_UPD_MUL: begin
				mul_a      = mue_q;
				rotate     = mul_done;
				write_tail = mul_done;
			end
			default: ;
		endcase
	end

	lmsanc_serial_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	// delay line and weight rings: shift in on a request (clearing both on a first sample), rotate per tap
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TAPS; i++) begin
				hist_q[i] <= '0;
				w_q[i]    <= '0;
			end
		end else if (accept) begin
			for (int i = TAPS - 1; i > 0; i--) begin
				hist_q[i] <= sample.first_sample ? '0 : hist_q[i-1];
			end
			hist_q[0] <= sample.ref_sample;
			if (sample.first_sample) begin
				for (int i = 0; i < TAPS; i++) begin
					w_q[i] <= '0;
				end
			end
		end else if (rotate) begin
			for (int i = 0; i < TAPS - 1; i++) begin
				hist_q[i] <= hist_q[i+1];
				w_q[i]    <= w_q[i+1];
			end
			hist_q[TAPS-1] <= hist_q[0];
			w_q[TAPS-1]    <= write_tail ? w_new : w_q[0];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
			m_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						k_q     <= '0;
						state_q <= ST_EST;
						if (act_ext == '0) begin
							m_q <= MW'(1);
						end else if (act_ext > MW'(TAPS)) begin
							m_q <= MW'(TAPS);
						end else begin
							m_q <= act_ext;
						end
					end
				end
				ST_EST: begin
					if (tap_active) begin
						state_q <= ST_EST_MUL;
					end else if (tap_last) begin
						state_q <= ST_ERR;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				ST_EST_MUL: begin
					if (mul_done) begin
						if (tap_last) begin
							state_q <= ST_ERR;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= ST_EST;
						end
					end
				end
				ST_ERR: begin
					state_q <= ST_MUE;
				end
				ST_MUE: begin
					if (mul_done) begin
						k_q     <= '0;
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					if (tap_active) begin
						state_q <= ST_UPD_MUL;
					end else if (tap_last) begin
						state_q <= ST_DONE;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				ST_UPD_MUL: begin
					if (mul_done) begin
						if (tap_last) begin
							state_q <= ST_DONE;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= ST_UPD;
						end
					end
				end
				ST_DONE: begin
					if (res_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers: desired sample, accumulator, estimate, error, mu*error
	always_ff @(posedge clk) begin
		if (accept) begin
			d_q   <= sample.desired_sample;
			acc_q <= '0;
		end
		if (state_q == ST_EST_MUL && mul_done) begin
			acc_q <= acc_q + ACC_W'(mul_prod);
		end
		if (state_q == ST_ERR) begin
			est_q <= est_sat;
			err_q <= err_sat;
		end
		if (state_q == ST_MUE && mul_done) begin
			mue_q <= mul_prod[lmsanc_pkg::MUE_W-1:0];
		end
		if (res_load) begin
			res_q.error_sample    <= err_q;
			res_q.estimate_sample <= est_q;
		end
	end

	// output register: hold the result until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule

// ----- verif/lms_result_checker.sv -----
// ----------------------------------------------------------------------------
// LMS noise canceller result checker
// Watches the request, result and register channels. Each accepted request
// runs through a fixed-point LMS predictor of its own (delay line, Q7.24
// weights, Q0.24 step). Each accepted result is compared field by field with
// the oldest prediction.
// ----------------------------------------------------------------------------
module lms_result_checker #(
	parameter int TAPS = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 sample_valid,
	input  logic                                 sample_ready,
	input  lmsanc_pkg::sample_t                  sample,
	input  logic                                 result_valid,
	input  logic                                 result_ready,
	input  lmsanc_pkg::result_t                  result,
	input  logic                                 cfg_valid,
	input  logic                                 cfg_ready,
	input  logic [lmsanc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [lmsanc_pkg::CFG_DATA_W-1:0]    cfg_data,
	output int                                   mismatches,
	output int                                   pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import lmsanc_pkg::*;

	localparam longint EST_ROUND = 64'sd1 <<< 23;
	localparam longint UPD_ROUND = 64'sd1 <<< 29;
	localparam longint W_MAX     = 64'sd2147483647;
	localparam longint W_MIN     = -64'sd2147483648;

	// predictor state
	logic [STEP_W-1:0]          step_cfg;
	logic [TAPS_CFG_W-1:0]      taps_cfg;
	logic signed [SAMPLE_W-1:0] history [TAPS];
	logic signed [WEIGHT_W-1:0] weights [TAPS];

	result_t expected_results [$];
	int      fails;

	function automatic longint clamp_to(input longint v, input longint lo, input longint hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// one LMS iteration: shift in, estimate, error, adapt the active weights
	function automatic result_t lms_iterate(input sample_t s);
		longint  acc;
		longint  est;
		longint  err;
		longint  mu;
		longint  delta;
		int      n;
		int      k;
		result_t r;

		if (taps_cfg == 0)
			n = 1;
		else if (taps_cfg > TAPS)
			n = TAPS;
		else
			n = int'(taps_cfg);

		if (s.first_sample) begin
			for (k = 0; k < TAPS; k++) begin
				history[k] = '0;
				weights[k] = '0;
			end
		end

		for (k = TAPS - 1; k > 0; k--)
			history[k] = history[k-1];
		history[0] = s.ref_sample;

		acc = 0;
		for (k = 0; k < n; k++)
			acc += longint'(weights[k]) * longint'(history[k]);
		est = clamp_to((acc + EST_ROUND) >>> 24, longint'(SMP_MIN), longint'(SMP_MAX));
		err = clamp_to(longint'(s.desired_sample) - est, longint'(SMP_MIN),
			longint'(SMP_MAX));

		// step is unsigned: widen without sign
		mu = longint'(step_cfg);
		for (k = 0; k < n; k++) begin
			delta = (mu * err * longint'(history[k]) + UPD_ROUND) >>> 30;
			weights[k] = WEIGHT_W'(clamp_to(longint'(weights[k]) + delta, W_MIN, W_MAX));
		end

		r.error_sample    = err[SAMPLE_W-1:0];
		r.estimate_sample = est[SAMPLE_W-1:0];
		return r;
	endfunction

	// track registers, queue predictions, compare results
	always @(posedge clk) begin
		result_t want;

		if (!arst_n) begin
			step_cfg = STEP_RESET;
			taps_cfg = TAPS_RESET;
			for (int k = 0; k < TAPS; k++) begin
				history[k] = '0;
				weights[k] = '0;
			end
			expected_results.delete();
			fails = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_STEP_SIZE:   step_cfg = cfg_data[STEP_W-1:0];
					REG_ACTIVE_TAPS: taps_cfg = cfg_data[TAPS_CFG_W-1:0];
					default: ;
				endcase
			end

			// pop before push: the result always belongs to an older request
			if (result_valid && result_ready) begin
				if (expected_results.size() == 0) begin
					$error("result with no request outstanding: error_sample %0d estimate_sample %0d",
						result.error_sample, result.estimate_sample);
					fails++;
				end else begin
					want = expected_results.pop_front();
					if (result.error_sample !== want.error_sample) begin
						$error("error_sample: expected %0d, actual %0d",
							want.error_sample, result.error_sample);
						fails++;
					end
					if (result.estimate_sample !== want.estimate_sample) begin
						$error("estimate_sample: expected %0d, actual %0d",
							want.estimate_sample, result.estimate_sample);
						fails++;
					end
				end
			end

			if (sample_valid && sample_ready)
				expected_results.push_back(lms_iterate(sample));
		end

		mismatches <= fails;
		pending    <= expected_results.size();
	end

endmodule

// ----- verif/tb_lms_adaptive_noise_canceller.sv -----
// ----------------------------------------------------------------------------
// LMS noise canceller testbench
// Drives requests and register writes into the canceller, with random idling
// on requests and random result stalls; runs a directed opening and then random
// adaptation runs (filtered reference plus noise, restarts, full-scale spikes)
// under many step and tap settings; the result checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_lms_adaptive_noise_canceller;
	timeunit 1ns;
	timeprecision 1ps;
	import lmsanc_pkg::*;

	localparam int     TAPS         = 8;
	localparam int     ITEM_TARGET  = 1200;
	localparam int     CALM_ITEMS   = 120;
	localparam int     TAIL_CYCLES  = 400;
	localparam longint LIMIT_CYCLES = 2_500_000;

	localparam logic [STEP_W-1:0] STEP_MAX = '1;

	// indexes past the register list, written to check they are ignored
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  sample_valid = 1'b0;
	logic                  sample_ready;
	sample_t               sample       = '0;
	logic                  result_valid;
	logic                  result_ready = 1'b0;
	result_t               result;
	logic                  cfg_valid    = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;

	int     mismatches;
	int     pending;
	bit     calm       = 1'b0;
	int     idle_pct   = 0;
	int     items_sent = 0;
	longint cycles     = 0;

	always #2 clk = ~clk;

	lms_adaptive_noise_canceller #(
		.TAPS(TAPS)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	lms_result_checker #(
		.TAPS(TAPS)
	) result_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mismatches   (mismatches),
		.pending      (pending)
	);

	// abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT_CYCLES) begin
			$display("lms_adaptive_noise_canceller verification failed");
			$finish;
		end
	end

	// stall the result side in bursts; the stall rate changes after each randomly drawn span
	initial begin : result_stalls
		int stall_left;
		int stall_pct;
		int span;

		stall_left = 0;
		stall_pct  = 0;
		span       = 0;
		forever begin
			@(posedge clk);
			if (span == 0) begin
				span = $urandom_range(32, 256);
				case ($urandom_range(0, 2))
					0:       stall_pct = 0;
					1:       stall_pct = 5;
					default: stall_pct = 40;
				endcase
			end
			span--;
			if (stall_left == 0 && !calm && $urandom_range(0, 99) < stall_pct)
				stall_left = $urandom_range(1, 11);
			if (stall_left > 0) begin
				result_ready <= 1'b0;
				stall_left--;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	function automatic sample_t pack_sample(input int x, input int d, input bit first);
		sample_t s;

		s.ref_sample     = x[SAMPLE_W-1:0];
		s.desired_sample = d[SAMPLE_W-1:0];
		s.first_sample   = first;
		return s;
	endfunction

	// offer one request, after an optional idle burst, and hold it until taken
	task automatic push_sample(input sample_t s);
		int gap;

		gap = (!calm && $urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 11) : 0;
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample       <= s;
		sample_valid <= 1'b1;
		do
			@(posedge clk);
		while (!sample_ready);
		items_sent++;
	endtask

	// drop the request line and hold until every result is back
	task automatic drain();
		sample_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_index <= idx;
		cfg_data  <= data;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
	endtask

	// program both registers, sometimes poke the spare indexes too
	task automatic set_config(input logic [CFG_DATA_W-1:0] step, input logic [CFG_DATA_W-1:0] taps,
			input bit spare);
		if (spare)
			cfg_write(REG_SPARE_A, CFG_DATA_W'($urandom));
		cfg_write(REG_STEP_SIZE, step);
		cfg_write(REG_ACTIVE_TAPS, taps);
		if (spare)
			cfg_write(REG_SPARE_B, CFG_DATA_W'($urandom));
		cfg_valid <= 1'b0;
	endtask

	// one adaptation run: restart, then mostly a filtered reference with noise
	task automatic feed_sequence(input int len);
		sample_t s;
		int      gain [3];
		int      past [3];
		int      mix;
		int      k;
		int      n;

		for (k = 0; k < 3; k++) begin
			gain[k] = $urandom_range(0, 1024) - 512;
			past[k] = 0;
		end
		for (n = 0; n < len; n++) begin
			past[2] = past[1];
			past[1] = past[0];
			case ($urandom_range(0, 19))
				0: begin
					// full-scale spike on both inputs
					s = pack_sample($urandom, $urandom, 1'b0);
				end
				1: begin
					// stray restart in the middle of a run
					s = pack_sample($urandom, $urandom, 1'b1);
				end
				default: begin
					s.ref_sample = SAMPLE_W'($urandom_range(0, 32767) - 16384);
					past[0] = s.ref_sample;
					mix = (gain[0] * past[0] + gain[1] * past[1] + gain[2] * past[2]) >>> 8;
					mix = mix + int'($urandom_range(0, 64)) - 32;
					if (mix > 32767)
						mix = 32767;
					else if (mix < -32768)
						mix = -32768;
					s = pack_sample(past[0], mix, 1'b0);
				end
			endcase
			past[0] = s.ref_sample;
			if (n == 0)
				s.first_sample = 1'b1;
			push_sample(s);
		end
	endtask

	initial begin : stimulus
		logic [CFG_DATA_W-1:0] step;
		logic [CFG_DATA_W-1:0] taps;
		int                    phase_left;
		int                    len;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: extremes and alternating bit patterns
		push_sample(pack_sample(32767, -32768, 1'b1));
		push_sample(pack_sample(-32768, 32767, 1'b0));
		push_sample(pack_sample(0, 0, 1'b0));
		push_sample(pack_sample(-1, 1, 1'b0));
		push_sample(pack_sample(21845, -21846, 1'b0));
		push_sample(pack_sample(-21846, 21845, 1'b0));

		// largest step, zero taps (acts as one), spare indexes ignored
		drain();
		set_config(CFG_DATA_W'(STEP_MAX), '0, 1'b1);
		push_sample(pack_sample(32767, 32767, 1'b1));
		repeat (5) push_sample(pack_sample(32767, 32767, 1'b0));
		push_sample(pack_sample(-32768, 32767, 1'b0));

		// frozen weights, taps above the line length (acts as the full line)
		drain();
		set_config('0, 20'd15, 1'b0);
		push_sample(pack_sample(-32768, -32768, 1'b0));
		push_sample(pack_sample(-32768, -32768, 1'b0));
		push_sample(pack_sample(1, -1, 1'b0));
		push_sample(pack_sample(32767, -32768, 1'b0));

		// smallest non-zero step; upper data bits of the taps write are dropped
		drain();
		set_config(20'd1, 20'hABCD3, 1'b0);
		push_sample(pack_sample(-32768, 32767, 1'b0));
		push_sample(pack_sample(12345, -12345, 1'b1));
		push_sample(pack_sample(-1, -1, 1'b0));
		push_sample(pack_sample(32767, 0, 1'b0));

		// random phases, each under its own settings
		while (items_sent < ITEM_TARGET) begin
			drain();
			if (items_sent >= ITEM_TARGET - CALM_ITEMS)
				calm <= 1'b1;

			case ($urandom_range(0, 7))
				0:       step = '0;
				1:       step = CFG_DATA_W'(STEP_MAX);
				2:       step = CFG_DATA_W'(STEP_RESET);
				3:       step = CFG_DATA_W'($urandom_range(0, STEP_MAX));
				default: step = CFG_DATA_W'($urandom_range(STEP_MAX / 2, STEP_MAX));
			endcase
			taps = CFG_DATA_W'($urandom);
			case ($urandom_range(0, 7))
				0:       taps[TAPS_CFG_W-1:0] = '0;
				1:       taps[TAPS_CFG_W-1:0] = TAPS_CFG_W'(TAPS);
				2:       taps[TAPS_CFG_W-1:0] = TAPS_CFG_W'($urandom_range(TAPS + 1, 15));
				default: taps[TAPS_CFG_W-1:0] = TAPS_CFG_W'($urandom_range(1, TAPS));
			endcase
			set_config(step, taps, $urandom_range(0, 3) == 0);

			case ($urandom_range(0, 2))
				0:       idle_pct = 0;
				1:       idle_pct = 30;
				default: idle_pct = 70;
			endcase

			phase_left = $urandom_range(60, 150);
			while (phase_left > 0) begin
				len = $urandom_range(20, 60);
				if (len > phase_left)
					len = phase_left;
				feed_sequence(len);
				phase_left -= len;
			end
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("lms_adaptive_noise_canceller verification clean");
		else
			$display("lms_adaptive_noise_canceller verification failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/lmsanc_pkg.sv
rtl/lmsanc_serial_mul.sv
rtl/lms_adaptive_noise_canceller.sv
verif/lms_result_checker.sv
verif/tb_lms_adaptive_noise_canceller.sv
